FILE: src/watc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly alarm table checker package
// Shared types and constants for the alarm cell chain and its top level.
// ----------------------------------------------------------------------------
package watc_pkg;

    // Default number of alarm entries (one cell per entry).
    localparam int ALARM_COUNT_DEF = 4;

    // Opcode values.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Day mask layout: bits 0-6 are days, bit 7 marks a weekly repeat.
    localparam int          REPEAT_BIT = 7;
    localparam logic [7:0]  DAY_BITS   = 8'h7f;
    localparam logic [2:0]  DAY_NONE   = 3'd7;

    typedef logic [1:0] t_idx;

    // One beat travelling down the chain of alarm cells.
    typedef struct packed {
        logic       is_write;
        logic       rollover;
        logic [2:0] weekday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        t_idx       entry_index;
        logic       entry_enable;
        logic [7:0] entry_week;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
        logic       hit;
        t_idx       hit_index;
    } t_probe;

endpackage
`default_nettype wire

FILE: src/weekly_alarm_table_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly alarm table checker core
// A chain of alarm cells, one per entry, checked in priority order per tick.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                 Payload
// --------  ---------  ------------------------  ---------------------------------
// command   in         start high, busy low      i_opcode .. i_entry_minute
// result    out        o_result_valid strobe     o_alarm_fired, o_fired_index,
//                                                o_fired_hour, o_fired_minute
//
// Each accepted beat walks down the chain of ALARM_COUNT cells, one cell per
// cycle. The result register is loaded as the beat leaves the last cell, and
// busy falls on that same edge, so no new beat is taken while one is in the
// chain; the next beat is accepted no earlier than the edge that ends the result
// cycle. The lowest-index cell sees the beat first, so priority among matching
// entries falls out of the order of the chain.
// Reset is synchronous and active low; it clears every entry to disabled with
// all day bits set, and clears the chain and the result strobe.
// The receiver cannot stall: the result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module weekly_alarm_table_checker_core #(
    parameter int ALARM_COUNT = watc_pkg::ALARM_COUNT_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    output logic       busy,
    input  wire        i_opcode,
    input  wire        i_day_rollover,
    input  wire  [2:0] i_weekday,
    input  wire  [4:0] i_now_hour,
    input  wire  [5:0] i_now_minute,
    input  wire  [1:0] i_entry_index,
    input  wire        i_entry_enable,
    input  wire  [7:0] i_entry_week,
    input  wire  [4:0] i_entry_hour,
    input  wire  [5:0] i_entry_minute,
    output logic       o_result_valid,
    output logic       o_alarm_fired,
    output logic [1:0] o_fired_index,
    output logic [4:0] o_fired_hour,
    output logic [5:0] o_fired_minute
);
    import watc_pkg::*;

    // Beat entering the chain and the links between neighbouring cells.
    logic   w_accept;
    t_probe w_head;
    logic   w_valid [ALARM_COUNT+1];
    t_probe w_probe [ALARM_COUNT+1];

    logic       r_busy;
    logic       n_busy;
    logic       r_out_valid;
    logic       r_fired;
    t_idx       r_index;
    logic [4:0] r_hour;
    logic [5:0] r_minute;

    assign w_accept = start && !r_busy;

    // The item is handed straight to the first cell on acceptance; the hit
    // marker starts clear and is set by the first matching cell.
    always_comb begin
        w_head.is_write     = i_opcode;
        w_head.rollover     = i_day_rollover;
        w_head.weekday      = i_weekday;
        w_head.now_hour     = i_now_hour;
        w_head.now_minute   = i_now_minute;
        w_head.entry_index  = i_entry_index;
        w_head.entry_enable = i_entry_enable;
        w_head.entry_week   = i_entry_week;
        w_head.entry_hour   = i_entry_hour;
        w_head.entry_minute = i_entry_minute;
        w_head.hit          = 1'b0;
        w_head.hit_index    = '0;
    end

    assign w_valid[0] = w_accept;
    assign w_probe[0] = w_head;

    for (genvar g = 0; g < ALARM_COUNT; g++) begin : g_cell
        watc_cell #(
            .CELL_INDEX(g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .i_probe (w_probe[g]),
            .o_valid (w_valid[g+1]),
            .o_probe (w_probe[g+1])
        );
    end

    // Busy from acceptance until the beat leaves the last cell; the result
    // register is loaded on that same edge.
    always_comb begin
        n_busy = r_busy;
        if (w_accept) begin
            n_busy = 1'b1;
        end else if (w_valid[ALARM_COUNT]) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= w_valid[ALARM_COUNT];
        end
    end

    // A write, or a tick that found nothing, reports all zero.
    always_ff @(posedge i_clk) begin
        if (w_valid[ALARM_COUNT]) begin
            r_fired  <= w_probe[ALARM_COUNT].hit;
            r_index  <= w_probe[ALARM_COUNT].hit ? w_probe[ALARM_COUNT].hit_index : '0;
            r_hour   <= w_probe[ALARM_COUNT].hit ? w_probe[ALARM_COUNT].now_hour : '0;
            r_minute <= w_probe[ALARM_COUNT].hit ? w_probe[ALARM_COUNT].now_minute : '0;
        end
    end

    assign busy           = r_busy;
    assign o_result_valid = r_out_valid;
    assign o_alarm_fired  = r_fired;
    assign o_fired_index  = r_index;
    assign o_fired_hour   = r_hour;
    assign o_fired_minute = r_minute;

endmodule
`default_nettype wire

FILE: src/watc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly alarm table cell
// Holds one alarm entry, acts on the beat passing by and hands it on.
// ----------------------------------------------------------------------------
module watc_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  watc_pkg::t_probe i_probe,
    output logic             o_valid,
    output watc_pkg::t_probe o_probe
);
    import watc_pkg::*;

    logic       r_enabled;
    logic [7:0] r_mask;
    logic [4:0] r_hour;
    logic [5:0] r_minute;
    logic       r_fired;

    logic       r_valid;
    t_probe     r_probe;
    t_probe     n_probe;

    logic       w_sel;
    logic       w_day_hit;
    logic       w_fired_eff;
    logic       w_match;

    always_comb begin
        w_sel       = i_valid && (i_probe.is_write == OP_WRITE) &&
                      (int'(i_probe.entry_index) == CELL_INDEX);
        w_day_hit   = (i_probe.weekday != DAY_NONE) && r_mask[i_probe.weekday];
        // A new day clears the fired flag before this entry is looked at.
        w_fired_eff = r_fired && !i_probe.rollover;
        w_match     = i_valid && (i_probe.is_write == OP_TICK) && !i_probe.hit &&
                      r_enabled && w_day_hit && !w_fired_eff &&
                      (r_hour == i_probe.now_hour) && (r_minute == i_probe.now_minute);
        n_probe = i_probe;
        if (w_match) begin
            n_probe.hit       = 1'b1;
            n_probe.hit_index = t_idx'(CELL_INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_mask    <= DAY_BITS;
            r_hour    <= '0;
            r_minute  <= '0;
            r_fired   <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_valid;
            if (w_sel) begin
                r_enabled <= i_probe.entry_enable;
                r_mask    <= i_probe.entry_week;
                r_hour    <= i_probe.entry_hour;
                r_minute  <= i_probe.entry_minute;
                r_fired   <= !i_probe.entry_enable;
            end else if (i_valid && (i_probe.is_write == OP_TICK)) begin
                if (w_match) begin
                    r_fired <= 1'b1;
                    if (!r_mask[REPEAT_BIT]) begin
                        r_mask[i_probe.weekday] <= 1'b0;
                    end
                end else if (i_probe.rollover) begin
                    r_fired <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_probe <= n_probe;
    end

    assign o_valid = r_valid;
    assign o_probe = r_probe;

endmodule
`default_nettype wire

FILE: src/watc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Weekly alarm table checker port checker
// Watches the core ports; checks handshake timing and zero quiet results.
// ----------------------------------------------------------------------------
module watc_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       start,
    input wire       busy,
    input wire       o_result_valid,
    input wire       o_alarm_fired,
    input wire [1:0] o_fired_index,
    input wire [4:0] o_fired_hour,
    input wire [5:0] o_fired_minute
);

    // An accepted command keeps the core busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("core not busy after an accepted command");

    // The core leaves busy exactly when a result is shown.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("busy fell without a result");

    // A result is never shown while a command is still in flight.
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // Each result lasts a single cycle.
    a_result_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    // A result without a firing alarm carries all zero fields.
    a_quiet_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_alarm_fired) |->
            (o_fired_index == 2'd0 && o_fired_hour == 5'd0 && o_fired_minute == 6'd0))
        else $error("non-firing result has non-zero fields");

endmodule

bind weekly_alarm_table_checker_core watc_checker u_watc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_alarm_fired  (o_alarm_fired),
    .o_fired_index  (o_fired_index),
    .o_fired_hour   (o_fired_hour),
    .o_fired_minute (o_fired_minute)
);
`default_nettype wire

FILE: tb/sv/weekly_alarm_table_checker_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weekly alarm table checker core testbench
// Drives write and tick beats through the command port, predicts every
// result from a private copy of the alarm table and checks each strobe.
// ----------------------------------------------------------------------------
module weekly_alarm_table_checker_core_test;

    import watc_pkg::*;

    localparam int ALARM_N = ALARM_COUNT_DEF;

    // The run should finish well inside this. Roughly 700 beats, plus idle
    // gaps, come to tens of microseconds.
    localparam time RUN_LIMIT = 2ms;

    // One command beat, one field per input port.
    typedef struct {
        logic       opcode;
        logic       rollover;
        logic [2:0] weekday;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [1:0] entry_index;
        logic       entry_enable;
        logic [7:0] entry_week;
        logic [4:0] entry_hour;
        logic [5:0] entry_minute;
    } t_beat;

    // One result beat as it appears on the result ports.
    typedef struct {
        logic       fired;
        logic [1:0] index;
        logic [4:0] hour;
        logic [5:0] minute;
    } t_outcome;

    // ------------------------------------------------------------------------
    // Scoreboard. It keeps its own copy of the alarm table, works out the
    // outcome of every accepted beat and holds it until the block shows its
    // result. Results come back in order, so a plain queue is enough.
    // ------------------------------------------------------------------------
    class alarm_table_scoreboard;
        bit         enabled [ALARM_N];
        logic [7:0] day_mask [ALARM_N];
        logic [4:0] stored_hour [ALARM_N];
        logic [5:0] stored_minute [ALARM_N];
        bit         done_today [ALARM_N];
        t_outcome   awaited_alarms [$];
        int         errors;

        function new();
            for (int k = 0; k < ALARM_N; k++) begin
                enabled[k]       = 1'b0;
                day_mask[k]      = DAY_BITS;
                stored_hour[k]   = '0;
                stored_minute[k] = '0;
                done_today[k]    = 1'b0;
            end
            errors = 0;
        endfunction

        // Applies an accepted beat to the table and queues the result it
        // should produce.
        function void note_beat(t_beat b);
            t_outcome   res;
            logic [7:0] day_bit;
            bit         found;
            res   = '{default: '0};
            found = 1'b0;
            if (b.opcode == OP_WRITE) begin
                // A disabled entry is loaded as already fired; a rollover clears
                // that flag, but the entry is still held back by its enable bit.
                enabled[b.entry_index]       = b.entry_enable;
                day_mask[b.entry_index]      = b.entry_week;
                stored_hour[b.entry_index]   = b.entry_hour;
                stored_minute[b.entry_index] = b.entry_minute;
                done_today[b.entry_index]    = ~b.entry_enable;
            end else begin
                if (b.rollover) begin
                    for (int k = 0; k < ALARM_N; k++) done_today[k] = 1'b0;
                end
                // Weekday seven selects no day bit: the repeat bit is never
                // taken as a day, so nothing can fire.
                if (b.weekday != DAY_NONE) begin
                    day_bit = 8'd1 << b.weekday;
                    for (int k = 0; k < ALARM_N; k++) begin
                        if (!found && enabled[k] && (day_mask[k] & day_bit) != 0 &&
                                !done_today[k] && stored_hour[k] == b.now_hour &&
                                stored_minute[k] == b.now_minute) begin
                            found         = 1'b1;
                            done_today[k] = 1'b1;
                            if (!day_mask[k][REPEAT_BIT]) day_mask[k] &= ~day_bit;
                            res.fired  = 1'b1;
                            res.index  = k[1:0];
                            res.hour   = b.now_hour;
                            res.minute = b.now_minute;
                        end
                    end
                end
            end
            awaited_alarms.push_back(res);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compares one result strobe with the oldest awaited outcome.
        function void check_outcome(t_outcome got);
            t_outcome want;
            if (awaited_alarms.size() == 0) begin
                $display("%0t: result beat with nothing awaited (fired %0d, index %0d)",
                         $time, got.fired, got.index);
                errors++;
                return;
            end
            want = awaited_alarms.pop_front();
            compare_field("alarm_fired", 8'(want.fired), 8'(got.fired));
            compare_field("fired_index", 8'(want.index), 8'(got.index));
            compare_field("fired_hour", 8'(want.hour), 8'(got.hour));
            compare_field("fired_minute", 8'(want.minute), 8'(got.minute));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic       i_opcode = 1'b0;
    logic       i_day_rollover = 1'b0;
    logic [2:0] i_weekday = '0;
    logic [4:0] i_now_hour = '0;
    logic [5:0] i_now_minute = '0;
    logic [1:0] i_entry_index = '0;
    logic       i_entry_enable = 1'b0;
    logic [7:0] i_entry_week = '0;
    logic [4:0] i_entry_hour = '0;
    logic [5:0] i_entry_minute = '0;
    logic       o_result_valid;
    logic       o_alarm_fired;
    logic [1:0] o_fired_index;
    logic [4:0] o_fired_hour;
    logic [5:0] o_fired_minute;

    alarm_table_scoreboard alarm_sb = new();

    // Sender idling can be switched off for a stretch of the run.
    bit idle_on = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    weekly_alarm_table_checker_core #(
        .ALARM_COUNT(ALARM_N)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_opcode(i_opcode),
        .i_day_rollover(i_day_rollover),
        .i_weekday(i_weekday),
        .i_now_hour(i_now_hour),
        .i_now_minute(i_now_minute),
        .i_entry_index(i_entry_index),
        .i_entry_enable(i_entry_enable),
        .i_entry_week(i_entry_week),
        .i_entry_hour(i_entry_hour),
        .i_entry_minute(i_entry_minute),
        .o_result_valid(o_result_valid),
        .o_alarm_fired(o_alarm_fired),
        .o_fired_index(o_fired_index),
        .o_fired_hour(o_fired_hour),
        .o_fired_minute(o_fired_minute)
    );

    // ------------------------------------------------------------------------
    // Beat builders. Fields that the opcode ignores are filled at random so
    // that every input bit toggles without changing the expected outcome.
    // ------------------------------------------------------------------------
    function automatic t_beat make_tick(int roll, int day, int hour, int minute);
        t_beat b;
        b.opcode       = OP_TICK;
        b.rollover     = roll[0];
        b.weekday      = day[2:0];
        b.now_hour     = hour[4:0];
        b.now_minute   = minute[5:0];
        b.entry_index  = $urandom_range(3);
        b.entry_enable = $urandom_range(1);
        b.entry_week   = $urandom_range(255);
        b.entry_hour   = $urandom_range(31);
        b.entry_minute = $urandom_range(63);
        return b;
    endfunction

    function automatic t_beat make_write(int idx, int en, int week, int hour, int minute);
        t_beat b;
        b.opcode       = OP_WRITE;
        b.rollover     = $urandom_range(1);
        b.weekday      = $urandom_range(7);
        b.now_hour     = $urandom_range(31);
        b.now_minute   = $urandom_range(63);
        b.entry_index  = idx[1:0];
        b.entry_enable = en[0];
        b.entry_week   = week[7:0];
        b.entry_hour   = hour[4:0];
        b.entry_minute = minute[5:0];
        return b;
    endfunction

    // Random beats lean towards useful sequences: ticks mostly land on the
    // time of a stored entry so that alarms really fire, and writes often
    // reuse another entry's time so that priority between entries matters.
    // A few hours and minutes run past their normal range on purpose.
    function automatic t_beat random_beat();
        int k;
        int hour;
        int minute;
        k = $urandom_range(ALARM_N - 1);
        if ($urandom_range(99) < 40) begin
            hour   = alarm_sb.stored_hour[k];
            minute = alarm_sb.stored_minute[k];
        end else if ($urandom_range(19) == 0) begin
            hour   = $urandom_range(31);
            minute = $urandom_range(63);
        end else begin
            hour   = $urandom_range(23);
            minute = $urandom_range(59);
        end
        if ($urandom_range(99) < 25) begin
            return make_write($urandom_range(3), $urandom_range(9) < 8,
                              $urandom_range(255), hour, minute);
        end
        if ($urandom_range(99) < 65) begin
            hour   = alarm_sb.stored_hour[k];
            minute = alarm_sb.stored_minute[k];
        end
        return make_tick($urandom_range(99) < 15,
                         ($urandom_range(15) == 0) ? 7 : $urandom_range(6),
                         hour, minute);
    endfunction

    // ------------------------------------------------------------------------
    // Sends one beat. It is called at a falling edge and returns at one.
    // Start stays high from one beat to the next unless the sender idles, so
    // it is assigned once per falling edge at most.
    // ------------------------------------------------------------------------
    task automatic send_beat(t_beat b);
        while (idle_on && $urandom_range(99) < 28) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_opcode       = b.opcode;
        i_day_rollover = b.rollover;
        i_weekday      = b.weekday;
        i_now_hour     = b.now_hour;
        i_now_minute   = b.now_minute;
        i_entry_index  = b.entry_index;
        i_entry_enable = b.entry_enable;
        i_entry_week   = b.entry_week;
        i_entry_hour   = b.entry_hour;
        i_entry_minute = b.entry_minute;
        start          = 1'b1;
        // The beat is taken at the first rising edge that sees busy low.
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        alarm_sb.note_beat(b);
        @(negedge i_clk);
    endtask

    // Result monitor: the strobe lasts one cycle and cannot be held off.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            alarm_sb.check_outcome('{o_alarm_fired, o_fired_index,
                                     o_fired_hour, o_fired_minute});
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, directed beats, random beats, drain.
    // ------------------------------------------------------------------------
    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Straight after reset every entry is disabled, even though the
        // stored time of midnight matches this tick.
        send_beat(make_tick(0, 0, 0, 0));
        // Two entries at the same time: the lower index wins first. Entry
        // zero does not repeat, so it loses the day it fires on.
        send_beat(make_write(0, 1, 8'h7f, 7, 30));
        send_beat(make_write(1, 1, 8'hff, 7, 30));
        send_beat(make_tick(0, 3, 7, 30));
        send_beat(make_tick(0, 3, 7, 30));
        // Both have fired today, so a third tick finds nothing.
        send_beat(make_tick(0, 3, 7, 30));
        // A new day clears the flags, but entry zero has lost this day.
        send_beat(make_tick(1, 3, 7, 30));
        // Weekday seven matches no entry, though the rollover still applies.
        send_beat(make_tick(1, 7, 7, 30));
        send_beat(make_tick(0, 4, 7, 30));
        // A disabled entry never fires.
        send_beat(make_write(2, 0, 8'hff, 23, 59));
        send_beat(make_tick(1, 6, 23, 59));
        // Hour and minute beyond their range are compared bit for bit. The
        // entry has one day only, and once fired it can never match again.
        send_beat(make_write(3, 1, 8'h01, 31, 63));
        send_beat(make_tick(0, 0, 31, 63));
        send_beat(make_tick(1, 0, 31, 63));
        // Repeat bit set but no day bits: it never fires.
        send_beat(make_write(3, 1, 8'h80, 0, 0));
        send_beat(make_tick(1, 0, 0, 0));
        // Rewriting an entry clears its fired flag, so it fires again.
        send_beat(make_write(2, 1, 8'hff, 23, 59));
        send_beat(make_tick(1, 6, 23, 59));
        send_beat(make_write(2, 1, 8'hff, 23, 59));
        send_beat(make_tick(0, 6, 23, 59));
        send_beat(make_tick(0, 6, 23, 59));
        // Extremes of the tick fields with nothing stored there.
        send_beat(make_tick(1, 6, 23, 0));
        send_beat(make_tick(0, 5, 0, 59));

        for (int n = 0; n < 650; n++) begin
            // A long stretch in the middle runs back to back.
            idle_on = !(n >= 250 && n < 400);
            send_beat(random_beat());
        end
        start = 1'b0;

        // Drain, then allow the pipeline depth once more for stray strobes.
        while (alarm_sb.awaited_alarms.size() != 0) @(posedge i_clk);
        repeat (ALARM_N + 4) @(posedge i_clk);

        if (alarm_sb.errors == 0 && alarm_sb.awaited_alarms.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
